[src/puss_pkg.sv]
package puss_pkg;

  // Table geometry
  localparam int EVENT_SLOTS = 4;
  localparam int SLOT_IDX_W  = 2;
  localparam int COUNT_W     = 3;

  // Field widths
  localparam int PROB_W = 16;
  localparam int VAL_W  = 24;
  localparam int QUOT_W = PROB_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BASE   = 3'd1;

  // One event of the table
  typedef struct packed {
    logic [PROB_W-1:0]       prob;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
  } event_t;

  // Status of the shared subtract/compare unit
  typedef struct packed {
    logic [QUOT_W-1:0] diff;
    logic              ge;
    logic              gt;
  } sub_res_t;

endpackage

[src/puss_cfg_regs.sv]
module puss_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [puss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [puss_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic [puss_pkg::COUNT_W-1:0]        event_count_o,
  output puss_pkg::event_t                    slots_o [puss_pkg::EVENT_SLOTS]
);
  import puss_pkg::*;

  logic [COUNT_W-1:0] event_count_q;
  event_t             slot_q [EVENT_SLOTS];

  // Hold the event count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_count_q <= COUNT_W'(1);
    end else if (cfg_we_i && (cfg_idx_i == REG_EVENT_COUNT)) begin
      event_count_q <= cfg_wdata_i[COUNT_W-1:0];
    end
  end

  // Hold the event slots; indexes past the table are dropped
  for (genvar i = 0; i < EVENT_SLOTS; i++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slot_q[i] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(REG_SLOT_BASE + i))) begin
        slot_q[i] <= cfg_wdata_i;
      end
    end
    assign slots_o[i] = slot_q[i];
  end

  assign event_count_o = event_count_q;

endmodule

[src/puss_sub_unit.sv]
module puss_sub_unit (
  input  logic [puss_pkg::QUOT_W-1:0] a_i,
  input  logic [puss_pkg::QUOT_W-1:0] b_i,
  output puss_pkg::sub_res_t          res_o
);
  import puss_pkg::*;

  logic [QUOT_W:0] diff;

  // Subtract with borrow; borrow clear means a >= b
  assign diff       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff = diff[QUOT_W-1:0];
  assign res_o.ge   = ~diff[QUOT_W];
  assign res_o.gt   = ~diff[QUOT_W] && (diff[QUOT_W-1:0] != '0);

endmodule

[src/puss_scale.sv]
module puss_scale (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic signed [puss_pkg::VAL_W-1:0]   lo_i,
  input  logic signed [puss_pkg::VAL_W-1:0]   hi_i,
  input  logic [puss_pkg::QUOT_W-1:0]         quot_i,
  output logic signed [puss_pkg::VAL_W-1:0]   value_o
);
  import puss_pkg::*;

  localparam int PROD_W = VAL_W + QUOT_W;

  logic signed [VAL_W:0]   span;
  logic                    span_neg;
  logic [VAL_W:0]          span_abs;
  logic [PROD_W-1:0]       prod_q;
  logic                    neg_q;
  logic [VAL_W:0]          off_mag;
  logic signed [VAL_W:0]   off;
  logic signed [VAL_W:0]   sum;

  // Span magnitude and sign
  assign span     = $signed({hi_i[VAL_W-1], hi_i}) - $signed({lo_i[VAL_W-1], lo_i});
  assign span_neg = span[VAL_W];
  assign span_abs = span_neg ? (~span + 1'b1) : span;

  // Register the product
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= span_abs[VAL_W-1:0] * quot_i;
      neg_q  <= span_neg;
    end
  end

  // Drop the fraction, restore sign, add the lower bound
  assign off_mag = prod_q[PROD_W-1:PROB_W];
  assign off     = neg_q ? $signed(~off_mag + 1'b1) : $signed(off_mag);
  assign sum     = $signed({lo_i[VAL_W-1], lo_i}) + off;
  assign value_o = sum[VAL_W-1:0];

endmodule

[src/piecewise_uniform_mixture_sampler_unit.sv]
// After the accepting edge: a table walk with one slot compare per step over up to 4 slots,
// then 17 restoring division steps, 1 multiply, 1 add and 1 output load to a valid result
// word. A flat slot or an overrun skips the division and goes from the walk straight to
// the output load. One word in flight: a new draw is taken only while idle, and an output
// stall holds the output load. Compares and division share one 17-bit subtract/compare
// unit. Reset (async, active low): count 1, slots zero, no word.
module piecewise_uniform_mixture_sampler_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [15:0]                         uniform_draw_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [23:0]                  sample_value_o,
  output logic [1:0]                          chosen_event_o,
  input  logic                                cfg_we_i,
  input  logic [puss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [puss_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import puss_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam int DIV_STEPS = QUOT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  logic [COUNT_W-1:0]      event_count;
  event_t                  slots [EVENT_SLOTS];
  event_t                  cur;

  logic [2:0]              state_q, state_d;
  logic [QUOT_W-1:0]       rem_q, rem_d;
  logic [SLOT_IDX_W-1:0]   n_q, n_d;
  logic [SLOT_IDX_W-1:0]   last_q, last_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [QUOT_W-1:0]       quot_q, quot_d;
  logic signed [VAL_W-1:0] res_q, res_d;
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_value_q;
  logic [SLOT_IDX_W-1:0]   out_event_q;

  logic [QUOT_W-1:0]       op_a, op_b;
  sub_res_t                sub;
  logic                    mul_load;
  logic signed [VAL_W-1:0] scaled;
  logic                    flat;
  logic                    out_free;
  logic                    out_load;
  logic [SLOT_IDX_W-1:0]   last_idx;

  puss_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .event_count_o(event_count),
    .slots_o      (slots)
  );

  puss_sub_unit u_sub (
    .a_i  (op_a),
    .b_i  (op_b),
    .res_o(sub)
  );

  puss_scale u_scale (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .lo_i   (cur.lo),
    .hi_i   (cur.hi),
    .quot_i (quot_q),
    .value_o(scaled)
  );

  // Clamp the event count to 1..EVENT_SLOTS, kept as the last slot index
  always_comb begin
    if (event_count == '0) begin
      last_idx = '0;
    end else if (event_count > COUNT_W'(EVENT_SLOTS)) begin
      last_idx = SLOT_IDX_W'(EVENT_SLOTS - 1);
    end else begin
      last_idx = SLOT_IDX_W'(event_count - 1'b1);
    end
  end

  assign cur      = slots[n_q];
  assign flat     = (cur.lo == cur.hi) || (cur.prob == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer and shared unit operand select
  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    n_d      = n_q;
    last_d   = last_q;
    step_d   = step_q;
    quot_d   = quot_q;
    res_d    = res_q;
    mul_load = 1'b0;
    out_load = 1'b0;
    op_a     = {1'b0, rem_q[PROB_W-1:0]};
    op_b     = {1'b0, cur.prob};

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rem_d   = {1'b0, uniform_draw_i};
          n_d     = '0;
          last_d  = last_idx;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sub.gt) begin
          rem_d = {1'b0, sub.diff[PROB_W-1:0]};
          if (n_q == last_q) begin
            // walked past the table: clamp to the last slot
            res_d   = flat ? cur.lo : cur.hi;
            state_d = ST_OUT;
          end else begin
            n_d = n_q + 1'b1;
          end
        end else if (flat) begin
          res_d   = cur.lo;
          state_d = ST_OUT;
        end else begin
          step_d  = '0;
          quot_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // one restoring step: integer bit first, then 16 fraction bits
        op_a   = (step_q == '0) ? rem_q : {rem_q[PROB_W-1:0], 1'b0};
        rem_d  = sub.ge ? sub.diff : op_a;
        quot_d = {quot_q[QUOT_W-2:0], sub.ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_load = 1'b1;
        state_d  = ST_ADD;
      end
      ST_ADD: begin
        res_d   = scaled;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    n_q    <= n_d;
    last_q <= last_d;
    step_q <= step_d;
    quot_q <= quot_d;
    res_q  <= res_d;
    if (out_load) begin
      out_value_q <= res_q;
      out_event_q <= n_q;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_value_q;
  assign chosen_event_o = out_event_q;

endmodule
